// ----- sv/smm_pkg.sv -----
`timescale 1ns / 1ps

package smm_pkg;

    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 34;
    localparam int QUEUE_DEPTH = 2;

    // what the front has found out about one element
    typedef enum logic [1:0] {
        KIND_A,
        KIND_B,
        KIND_B_LAST
    } elem_kind_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        elem_kind_t               kind;
    } queue_item_t;

    // travels with each multiply-accumulate through the back pipeline
    typedef struct packed {
        logic first_term;
        logic last_term;
        logic last_entry;
    } mac_tag_t;

endpackage

// ----- sv/smm_if.sv -----
`timescale 1ns / 1ps

interface elem_if;
    logic                                valid;
    logic                                ready;
    logic signed [smm_pkg::ELEM_W-1:0]   element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface result_if;
    logic                                valid;
    logic                                ready;
    logic signed [smm_pkg::PROD_W-1:0]   product_value;
    logic                                last_entry;

    modport source (output valid, output product_value, output last_entry, input ready);
    modport sink   (input valid, input product_value, input last_entry, output ready);
endinterface

// ----- sv/smm_ram.sv -----
`timescale 1ns / 1ps

module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/smm_queue.sv -----
`timescale 1ns / 1ps

module smm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  smm_pkg::queue_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output smm_pkg::queue_item_t head_item
);

    localparam int DEPTH = smm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    smm_pkg::queue_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/smm_front.sv -----
`timescale 1ns / 1ps

module smm_front #(
    parameter int MATRIX_ORDER = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    elem_if.sink                 elements,
    input  logic                 queue_full,
    output logic                 push,
    output smm_pkg::queue_item_t push_item
);

    localparam int CELLS = MATRIX_ORDER * MATRIX_ORDER;
    localparam int POS_W = $clog2(2 * CELLS);

    logic [POS_W-1:0] pos_reg, pos_next;

    assign elements.ready = !queue_full;
    assign push           = elements.valid && !queue_full;

    always_comb
    begin
        push_item.value = elements.element_value;
        if (pos_reg < POS_W'(CELLS))
        begin
            push_item.kind = smm_pkg::KIND_A;
        end
        else if (pos_reg == POS_W'(2 * CELLS - 1))
        begin
            push_item.kind = smm_pkg::KIND_B_LAST;
        end
        else
        begin
            push_item.kind = smm_pkg::KIND_B;
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            pos_next = (pos_reg == POS_W'(2 * CELLS - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- sv/smm_back.sv -----
`timescale 1ns / 1ps

module smm_back #(
    parameter int MATRIX_ORDER = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 queue_not_empty,
    input  smm_pkg::queue_item_t head_item,
    output logic                 pop,
    result_if.source             products
);

    localparam int CELLS  = MATRIX_ORDER * MATRIX_ORDER;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(MATRIX_ORDER);
    localparam int ELEM_W = smm_pkg::ELEM_W;
    localparam int PROD_W = smm_pkg::PROD_W;
    localparam int MUL_W  = 2 * ELEM_W;
    localparam int SUM_W  = MUL_W + $clog2(MATRIX_ORDER);
    localparam int ACC_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

    // write side
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              we_a, we_b, start;

    // issue side
    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] a_addr, b_addr;
    logic              adv, issue;
    smm_pkg::mac_tag_t issue_tag;

    // pipeline
    logic                     s1_valid_reg, s1_valid_next;
    smm_pkg::mac_tag_t        s1_tag_reg;
    logic [ELEM_W-1:0]        a_data, b_data;
    logic                     s2_valid_reg, s2_valid_next;
    smm_pkg::mac_tag_t        s2_tag_reg;
    logic signed [MUL_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_sum;
    logic                     ovf;
    logic signed [PROD_W-1:0] sat_value;

    logic                     out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] out_value_reg;
    logic                     out_last_reg;

    assign pop   = queue_not_empty && !busy_reg;
    assign we_a  = pop && (head_item.kind == smm_pkg::KIND_A);
    assign we_b  = pop && (head_item.kind != smm_pkg::KIND_A);
    assign start = pop && (head_item.kind == smm_pkg::KIND_B_LAST);

    // whole pipeline holds while a finished entry waits at the output
    assign adv   = !out_valid_reg || products.ready;
    assign issue = busy_reg && adv;

    assign a_addr = ADDR_W'(int'(row_reg) * MATRIX_ORDER + int'(k_reg));
    assign b_addr = ADDR_W'(int'(k_reg) * MATRIX_ORDER + int'(col_reg));

    always_comb
    begin
        issue_tag.first_term = (k_reg == '0);
        issue_tag.last_term  = (k_reg == IDX_W'(MATRIX_ORDER - 1));
        issue_tag.last_entry = issue_tag.last_term
                               && (col_reg == IDX_W'(MATRIX_ORDER - 1))
                               && (row_reg == IDX_W'(MATRIX_ORDER - 1));
    end

    smm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_left_ram (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_addr_reg),
        .wdata (head_item.value),
        .re    (issue),
        .raddr (a_addr),
        .rdata (a_data)
    );

    smm_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_right_ram (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_addr_reg),
        .wdata (head_item.value),
        .re    (issue),
        .raddr (b_addr),
        .rdata (b_data)
    );

    // write address wraps per matrix; A and B arrive in order
    always_comb
    begin
        wr_addr_next = wr_addr_reg;
        if (pop)
        begin
            wr_addr_next = (wr_addr_reg == ADDR_W'(CELLS - 1)) ? '0 : wr_addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            row_next  = '0;
            col_next  = '0;
            k_next    = '0;
        end
        else if (issue)
        begin
            if (k_reg == IDX_W'(MATRIX_ORDER - 1))
            begin
                k_next = '0;
                if (col_reg == IDX_W'(MATRIX_ORDER - 1))
                begin
                    col_next = '0;
                    if (row_reg == IDX_W'(MATRIX_ORDER - 1))
                    begin
                        row_next  = '0;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    assign s1_valid_next = adv ? issue : s1_valid_reg;
    assign s2_valid_next = adv ? s1_valid_reg : s2_valid_reg;

    assign acc_sum = s2_tag_reg.first_term ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    // clamp to the output range; bits above the output sign must all match it
    assign ovf = !((&acc_sum[ACC_W-1:PROD_W-1]) || !(|acc_sum[ACC_W-1:PROD_W-1]));

    always_comb
    begin
        if (!ovf)
        begin
            sat_value = acc_sum[PROD_W-1:0];
        end
        else if (acc_sum[ACC_W-1])
        begin
            sat_value = {1'b1, {(PROD_W-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(PROD_W-1){1'b1}}};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv && s2_valid_reg && s2_tag_reg.last_term)
        begin
            out_valid_next = 1'b1;
        end
        else if (products.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg   <= '0;
            busy_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_addr_reg   <= wr_addr_next;
            busy_reg      <= busy_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            k_reg         <= k_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg <= issue_tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= $signed(a_data) * $signed(b_data);
            if (s2_valid_reg)
            begin
                acc_reg <= acc_sum;
                if (s2_tag_reg.last_term)
                begin
                    out_value_reg <= sat_value;
                    out_last_reg  <= s2_tag_reg.last_entry;
                end
            end
        end
    end

    assign products.valid         = out_valid_reg;
    assign products.product_value = out_value_reg;
    assign products.last_entry    = out_last_reg;

endmodule

// ----- sv/square_matrix_multiply.sv -----
`timescale 1ns / 1ps

// Square matrix multiplier. Feed the MATRIX_ORDER^2 elements of A, row-major, then those
// of B; the block returns the MATRIX_ORDER^2 entries of C = A * B row-major, 34-bit signed,
// last_entry set on the final one. Loading takes one element per cycle while the queue
// has room. The element that completes B starts the product, which runs on a single
// multiply-accumulate unit reading both matrix memories once per cycle, unless the output
// stalls, for MATRIX_ORDER^3 multiply-accumulates. Each term passes the memory read, the
// product register and the accumulator; an entry is registered at the output once its last
// term is summed. A two-entry queue sits between the input and the engine, so two more
// elements are taken while a product runs and then the input stalls. Output stalls hold
// the engine and so lengthen a product.
module square_matrix_multiply #(
    parameter int MATRIX_ORDER = 3
) (
    input  logic      clk,
    input  logic      rst_n,
    elem_if.sink      elements,
    result_if.source  products
);

    smm_pkg::queue_item_t push_item, head_item;
    logic                 push, queue_full, pop, queue_not_empty;

    smm_front #(.MATRIX_ORDER(MATRIX_ORDER)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .elements   (elements),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    smm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    smm_back #(.MATRIX_ORDER(MATRIX_ORDER)) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .queue_not_empty (queue_not_empty),
        .head_item       (head_item),
        .pop             (pop),
        .products        (products)
    );

endmodule

// ----- sv/smm_checker.sv -----
`timescale 1ns / 1ps

module smm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [smm_pkg::PROD_W-1:0] out_value,
    input logic                              out_last
);

    // a waiting beat stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
        else $error("result payload changed while stalled");

    // nothing can be pending right out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // the last entry drains the engine; the next matrix needs a full reload
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_last |=> !out_valid)
        else $error("result beat right after the last entry");

endmodule

bind square_matrix_multiply smm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (products.valid),
    .out_ready (products.ready),
    .out_value (products.product_value),
    .out_last  (products.last_entry)
);

// ----- tb/square_matrix_multiply_test.sv -----
`timescale 1ns / 1ps

module square_matrix_multiply_test;

    localparam int ELEM_W      = smm_pkg::ELEM_W;
    localparam int PROD_W      = smm_pkg::PROD_W;
    localparam int ORDER       = 3;
    localparam int CELLS       = ORDER * ORDER;
    localparam int DIRECTED    = 25;
    localparam int ITEM_TARGET = 180;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 200000;
    localparam longint SUM_MAX = 64'sd8589934591;
    localparam longint SUM_MIN = -64'sd8589934592;

    typedef struct packed {
        logic signed [ELEM_W-1:0] value;
        logic                     typed;
    } stim_row_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] value;
        logic                     last;
    } product_t;

    // A rows: all min, all max, zero; B columns: min, max, zero
    localparam stim_row_t DIRECTED_ROWS [DIRECTED] = '{
        '{-16'sd32768, 1'b0}, '{-16'sd32768, 1'b0}, '{-16'sd32768, 1'b0},
        '{16'sd32767, 1'b0},  '{16'sd32767, 1'b0},  '{16'sd32767, 1'b0},
        '{16'sd0, 1'b0},      '{16'sd0, 1'b0},      '{16'sd0, 1'b0},
        '{-16'sd32768, 1'b0}, '{16'sd32767, 1'b0},  '{16'sd0, 1'b0},
        '{-16'sd32768, 1'b0}, '{16'sd32767, 1'b0},  '{16'sd0, 1'b0},
        '{-16'sd32768, 1'b0}, '{16'sd32767, 1'b0},  '{16'sd0, 1'b1},
        // next item after completion opens a new A
        '{16'sd21845, 1'b0},  '{-16'sd21846, 1'b0}, '{16'sd1, 1'b0},
        '{-16'sd1, 1'b0},     '{16'sd0, 1'b0},      '{16'sd255, 1'b0},
        '{-16'sd256, 1'b0}
    };

    localparam logic signed [PROD_W-1:0] EXTREME_PRODUCTS [CELLS] = '{
        34'sd3221225472, -34'sd3221127168, 34'sd0,
        -34'sd3221127168, 34'sd3221028867, 34'sd0,
        34'sd0, 34'sd0, 34'sd0
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    elem_if   elem_bus ();
    result_if result_bus ();

    square_matrix_multiply #(
        .MATRIX_ORDER(ORDER)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .elements(elem_bus.sink),
        .products(result_bus.source)
    );

    always #2 clk = ~clk;

    logic signed [ELEM_W-1:0] left_store  [CELLS];
    logic signed [ELEM_W-1:0] right_store [CELLS];
    int       load_count = 0;
    product_t pending_products [$];
    int       items_accepted = 0;
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       long_hold_done = 1'b0;

    // store one element; the one that completes B yields the whole product
    task automatic load_and_multiply(input logic signed [ELEM_W-1:0] v, input logic typed);
        product_t entry;
        longint   acc;
        if (load_count < CELLS)
            left_store[load_count] = v;
        else
            right_store[load_count - CELLS] = v;
        load_count++;
        if (load_count == 2 * CELLS)
        begin
            load_count = 0;
            for (int r = 0; r < ORDER; r++)
            begin
                for (int c = 0; c < ORDER; c++)
                begin
                    acc = 0;
                    for (int k = 0; k < ORDER; k++)
                        acc += longint'(left_store[r * ORDER + k]) *
                               longint'(right_store[k * ORDER + c]);
                    if (acc > SUM_MAX)
                        acc = SUM_MAX;
                    if (acc < SUM_MIN)
                        acc = SUM_MIN;
                    entry.value = typed ? EXTREME_PRODUCTS[r * ORDER + c] : acc[PROD_W-1:0];
                    entry.last  = (r == ORDER - 1) && (c == ORDER - 1);
                    pending_products.push_back(entry);
                end
            end
        end
    endtask

    // offer one beat, wait for it to be taken, then maybe open a gap
    task automatic send_element(input logic signed [ELEM_W-1:0] v, input logic typed);
        int gap;
        elem_bus.valid         <= 1'b1;
        elem_bus.element_value <= v;
        @(posedge clk);
        while (!elem_bus.ready)
            @(posedge clk);
        load_and_multiply(v, typed);
        items_accepted++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                elem_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            4: return ELEM_W'($signed($urandom_range(0, 8)) - 4);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    initial
    begin
        elem_bus.valid         <= 1'b0;
        elem_bus.element_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED; i++)
            send_element(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed);
        while (items_accepted < ITEM_TARGET || load_count != 0)
            send_element(pick_element(), 1'b0);
        elem_bus.valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0 && pending_products.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: stretches of always-ready, coin-flip and mostly-stalled,
    // plus one long hold-off so the input side backs up
    initial
    begin
        int stretch;
        int mode;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!long_hold_done && items_accepted >= 60)
            begin
                long_hold_done = 1'b1;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    result_bus.ready <= 1'b0;
                end
            end
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 60);
            repeat (stretch)
            begin
                @(posedge clk);
                case (mode)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= 1'($urandom_range(0, 1));
                    default: result_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (pending_products.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: product_value=%0d last_entry=%0b",
                             result_bus.product_value, result_bus.last_entry);
            end
            else
            begin
                want = pending_products.pop_front();
                if (result_bus.product_value !== want.value ||
                    result_bus.last_entry !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: value exp %0d got %0d, last exp %0b got %0b",
                                 want.value, result_bus.product_value,
                                 want.last, result_bus.last_entry);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
